FILE: hdl/bpap_pkg.sv
`default_nettype none
package bpap_pkg;
    localparam int T_FRAC_BITS_DEF = 10;
    localparam int WINDOW_SIZE_DEF = 1024;
    localparam int POS_FRAC  = 10;
    localparam int COORD_W   = 10;
    localparam int POS_W     = COORD_W + POS_FRAC;
    localparam int T_W       = 11;
    localparam int CFG_IDX_W = 3;
    localparam int INT_W     = 8;
    localparam int DIST_W    = 11;
    localparam int NEAR_LIMIT = 51;
    localparam int FAR_SCALE  = 1792;

    typedef struct packed {
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic               ix;
        logic               iy;
        logic [POS_FRAC-1:0] rx;
        logic [POS_FRAC-1:0] ry;
    } point_t;
endpackage
`default_nettype wire

FILE: hdl/bezier_point_antialias_plotter.sv
`default_nettype none
// Channel   | Dir | Contents
// s_axis    | in  | tdata[10:0] t_value
// m_axis    | out | tdata[27:0] {intensity, pixel_y, pixel_x}, tuser corner, tlast last
// cfg       | in  | cfg_we / cfg_index / cfg_data, control points x0,y0..x3,y3
// One item per cycle enters a 9-stage pipeline while it is not stalled (3 interpolation rounds, corner
// offsets, square, two root halves, two scale steps); four corners leave one per cycle
// from the output serializer while m_axis_tready is high, so the single result port
// limits the sustained item rate.
// Reset clears valid bits and control points; payload registers are not reset.
// A stall freezes the whole pipeline; the serializer holds an item while the next waits.
module bezier_point_antialias_plotter
    import bpap_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,   // t_value[10:0]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [31:0]          m_axis_tdata,   // pixel_x, pixel_y, intensity
    output logic      [1:0]           m_axis_tuser,   // corner
    output logic                      m_axis_tlast,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data
);
    localparam int NST = 9;
    logic [COORD_W-1:0] ctrl_reg [8];
    logic [NST-1:0]     vld_reg;
    logic               en;
    logic [T_FRAC_BITS:0] t_sat;
    logic [POS_W-1:0]   px, py;
    point_t             pt_reg, pt1_reg, pt2_reg, pt3_reg, pt4_reg, pt5_reg;
    logic [POS_FRAC:0]  dxf, dxc, dyf, dyc;
    logic [INT_W-1:0]   inten [4];
    logic [INT_W-1:0]   hold_int_reg [4];
    point_t             hold_pt_reg;
    logic [1:0]         k_reg;
    logic               busy_reg;
    logic               out_take;
    logic [COORD_W:0]   qx, qy;
    logic [COORD_W-1:0] wx, wy;

    // control point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++) ctrl_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            ctrl_reg[cfg_index] <= cfg_data;
        end
    end

    // pipeline advances unless its last stage is full and the serializer is busy without its last corner being accepted
    assign out_take = vld_reg[NST-1] && (!busy_reg || (m_axis_tready && k_reg == 2'd3));
    assign en = !vld_reg[NST-1] || out_take;
    assign s_axis_tready = en;

    assign t_sat = (32'(s_axis_tdata[T_W-1:0]) > 32'(1 << T_FRAC_BITS))
                   ? (T_FRAC_BITS+1)'(1 << T_FRAC_BITS)
                   : (T_FRAC_BITS+1)'(s_axis_tdata[T_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    bpap_eval #(.TFB(T_FRAC_BITS)) u_eval (.clk, .en, .t(t_sat), .ctrl(ctrl_reg),
        .px, .py);

    // point split and corner offsets
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg.fx <= px[POS_W-1:POS_FRAC];
            pt_reg.fy <= py[POS_W-1:POS_FRAC];
            pt_reg.rx <= px[POS_FRAC-1:0];
            pt_reg.ry <= py[POS_FRAC-1:0];
            pt_reg.ix <= px[POS_FRAC-1:0] != '0;
            pt_reg.iy <= py[POS_FRAC-1:0] != '0;
            pt1_reg <= pt_reg;
            pt2_reg <= pt1_reg;
            pt3_reg <= pt2_reg;
            pt4_reg <= pt3_reg;
            pt5_reg <= pt4_reg;
        end
    end

    assign dxf = (POS_FRAC+1)'(pt_reg.rx);
    assign dyf = (POS_FRAC+1)'(pt_reg.ry);
    assign dxc = pt_reg.ix ? (POS_FRAC+1)'(1 << POS_FRAC) - dxf : '0;
    assign dyc = pt_reg.iy ? (POS_FRAC+1)'(1 << POS_FRAC) - dyf : '0;

    bpap_shade u_sh0 (.clk, .en, .dx(dxf), .dy(dyf), .inten_reg(inten[0]));
    bpap_shade u_sh1 (.clk, .en, .dx(dxf), .dy(dyc), .inten_reg(inten[1]));
    bpap_shade u_sh2 (.clk, .en, .dx(dxc), .dy(dyf), .inten_reg(inten[2]));
    bpap_shade u_sh3 (.clk, .en, .dx(dxc), .dy(dyc), .inten_reg(inten[3]));

    // output serializer, one corner per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (out_take)
        begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
        end
        else if (busy_reg && m_axis_tready)
        begin
            if (k_reg == 2'd3)
                busy_reg <= 1'b0;
            k_reg <= k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            hold_pt_reg <= pt5_reg;
            for (int i = 0; i < 4; i++) hold_int_reg[i] <= inten[i];
        end
    end

    assign qx = (COORD_W+1)'(hold_pt_reg.fx) + (COORD_W+1)'(k_reg[1] && hold_pt_reg.ix);
    assign qy = (COORD_W+1)'(hold_pt_reg.fy) + (COORD_W+1)'(k_reg[0] && hold_pt_reg.iy);
    assign wx = (32'(qx) >= 32'(WINDOW_SIZE)) ? COORD_W'(WINDOW_SIZE-1) : qx[COORD_W-1:0];
    assign wy = (32'(qy) >= 32'(WINDOW_SIZE)) ? COORD_W'(WINDOW_SIZE-1) : qy[COORD_W-1:0];

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {4'b0000, hold_int_reg[k_reg], wy, wx};
    assign m_axis_tuser  = k_reg;
    assign m_axis_tlast  = k_reg == 2'd3;

    a_last_k: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> k_reg == 2'd0)
        else $error("corner count wrapped wrong");
    a_take_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> vld_reg[NST-1])
        else $error("empty stage taken");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved in stall");
endmodule
`default_nettype wire

FILE: hdl/bpap_lerp.sv
`default_nettype none
// One registered linear interpolation of a de Casteljau round.
module bpap_lerp
    import bpap_pkg::*;
#(
    parameter int TFB = T_FRAC_BITS_DEF
)(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [TFB:0]     t,
    input  wire logic [POS_W-1:0] a,
    input  wire logic [POS_W-1:0] b,
    output logic      [POS_W-1:0] q_reg
);
    localparam int PW = POS_W + TFB + 2;
    logic [PW-1:0] sum;
    logic [TFB:0]  tc;

    assign tc  = (TFB+1)'(1 << TFB) - t;
    assign sum = PW'(a) * PW'(tc) + PW'(b) * PW'(t) + PW'(1 << (TFB-1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= POS_W'(sum >> TFB);
        end
    end
endmodule
`default_nettype wire

FILE: hdl/bpap_eval.sv
`default_nettype none
// Three-stage de Casteljau evaluation of both axes.
module bpap_eval
    import bpap_pkg::*;
#(
    parameter int TFB = T_FRAC_BITS_DEF
)(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [TFB:0]       t,
    input  wire logic [COORD_W-1:0] ctrl [8],
    output logic      [POS_W-1:0]   px,
    output logic      [POS_W-1:0]   py
);
    logic [TFB:0]     t1_reg, t2_reg;
    logic [POS_W-1:0] s1 [6];
    logic [POS_W-1:0] s2 [4];
    logic [POS_W-1:0] cp [8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t;
            t2_reg <= t1_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 8; g++)
        begin : g_cp
            assign cp[g] = {ctrl[g], POS_FRAC'(0)};
        end
        // axis a (0 = x, 1 = y), segment k
        for (g = 0; g < 6; g++)
        begin : g_r1
            bpap_lerp #(.TFB(TFB)) u_l (.clk, .en, .t(t),
                .a(cp[2*(g%3) + g/3]), .b(cp[2*(g%3+1) + g/3]), .q_reg(s1[g]));
        end
        for (g = 0; g < 4; g++)
        begin : g_r2
            bpap_lerp #(.TFB(TFB)) u_l (.clk, .en, .t(t1_reg),
                .a(s1[3*(g/2) + g%2]), .b(s1[3*(g/2) + g%2 + 1]), .q_reg(s2[g]));
        end
    endgenerate

    bpap_lerp #(.TFB(TFB)) u_lx (.clk, .en, .t(t2_reg), .a(s2[0]), .b(s2[1]), .q_reg(px));
    bpap_lerp #(.TFB(TFB)) u_ly (.clk, .en, .t(t2_reg), .a(s2[2]), .b(s2[3]), .q_reg(py));
endmodule
`default_nettype wire

FILE: hdl/bpap_shade.sv
`default_nettype none
// Distance and intensity for one corner: square, two root halves, two scale steps.
module bpap_shade
    import bpap_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [POS_FRAC:0]   dx,
    input  wire logic [POS_FRAC:0]   dy,
    output logic      [INT_W-1:0]    inten_reg
);
    localparam int SW    = 2*POS_FRAC + 3;
    localparam int VW    = 2*DIST_W;
    localparam int RT_LO = 5;           // root digits resolved in the second half
    localparam int MW    = DIST_W + 4;
    // floor(q/7) equals (q*RECIP_7) >> RECIP_SH for every q below 5461
    localparam int RECIP_7  = 2341;
    localparam int RECIP_SH = 14;
    localparam logic [MW-1:0] FAR_W = MW'(FAR_SCALE);

    typedef struct packed {
        logic [VW-1:0]     rem;
        logic [DIST_W-1:0] root;
    } sq_t;

    logic [SW-1:0]       s_reg;
    logic [VW-1:0]       v;
    sq_t                 sq_hi;
    sq_t                 sq_lo;
    sq_t                 sq_reg;
    logic [2*RT_LO-1:0]  v_lo_reg;
    logic [DIST_W-1:0]   d_reg;
    logic [MW-1:0]       d10;
    logic                near_reg;
    logic                far_reg;
    logic [DIST_W-1:0]   m_reg;
    logic [DIST_W+7:0]   m255;
    logic [DIST_W+11:0]  qr;

    // one digit of the restoring square root
    function automatic sq_t sq_step(sq_t cur, logic [1:0] pair);
        sq_t           nxt;
        logic [VW-1:0] r2;
        logic [VW-1:0] trial;
        r2    = {cur.rem[VW-3:0], pair};
        trial = VW'({cur.root, 2'b01});
        if (r2 >= trial)
        begin
            nxt.rem  = r2 - trial;
            nxt.root = {cur.root[DIST_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = r2;
            nxt.root = {cur.root[DIST_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // upper root digits
    always_comb
    begin
        v     = VW'(s_reg[SW-1:4]);
        sq_hi = '0;
        for (int i = DIST_W-1; i >= RT_LO; i--)
            sq_hi = sq_step(sq_hi, v[2*i +: 2]);
    end

    // lower root digits
    always_comb
    begin
        sq_lo = sq_reg;
        for (int i = RT_LO-1; i >= 0; i--)
            sq_lo = sq_step(sq_lo, v_lo_reg[2*i +: 2]);
    end

    // 255*m/1792 as ((255*m) >> 8) / 7
    assign d10  = MW'(d_reg) * MW'(10);
    assign m255 = {m_reg, 8'd0} - (DIST_W+8)'(m_reg);
    assign qr   = (DIST_W+12)'(m255[DIST_W+7:8]) * (DIST_W+12)'(RECIP_7);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= SW'(dx) * SW'(dx) + SW'(dy) * SW'(dy);
            sq_reg   <= sq_hi;
            v_lo_reg <= v[2*RT_LO-1:0];
            d_reg    <= sq_lo.root;
            near_reg <= d_reg <= DIST_W'(NEAR_LIMIT);
            far_reg  <= d10 >= FAR_W;
            m_reg    <= DIST_W'(FAR_W - d10);
            if (near_reg)
                inten_reg <= 8'd255;
            else if (far_reg)
                inten_reg <= '0;
            else
                inten_reg <= qr[RECIP_SH +: INT_W];
        end
    end
endmodule
`default_nettype wire
